/* sv/pm384_pkg.sv */
// ----------------------------------------------------------------------------
// pm384_pkg: shared types and round logic
// request/result structs, state and key types, and the combinational
// column sp-box round used by every round stage
// ----------------------------------------------------------------------------
package pm384_pkg;

  localparam int ROUND_COUNT = 24;
  localparam int RIDX_W      = $clog2(ROUND_COUNT + 1);
  localparam int WORD_W      = 32;
  localparam int NUM_WORDS   = 12;
  localparam int KEY_WORDS   = 8;
  localparam int NUM_KEYREGS = 4;
  localparam int KEYREG_W    = 64;
  localparam int CFG_IDX_W   = $clog2(NUM_KEYREGS);
  // counted from the accepting edge (which loads the input register), through
  // the round registers and the output register, to the edge that takes the result
  localparam int LATENCY     = ROUND_COUNT + 2;

  localparam logic [WORD_W-1:0] ROUND_CONST = 32'h79379E00;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  typedef struct packed {
    logic [WORD_W-1:0] in_word_0;
    logic [WORD_W-1:0] in_word_1;
    logic [WORD_W-1:0] in_word_2;
    logic [WORD_W-1:0] in_word_3;
    logic [WORD_W-1:0] in_word_4;
    logic [WORD_W-1:0] in_word_5;
    logic [WORD_W-1:0] in_word_6;
    logic [WORD_W-1:0] in_word_7;
    logic [WORD_W-1:0] in_word_8;
    logic [WORD_W-1:0] in_word_9;
    logic [WORD_W-1:0] in_word_10;
    logic [WORD_W-1:0] in_word_11;
  } in_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word_0;
    logic [WORD_W-1:0] out_word_1;
    logic [WORD_W-1:0] out_word_2;
    logic [WORD_W-1:0] out_word_3;
    logic [WORD_W-1:0] out_word_4;
    logic [WORD_W-1:0] out_word_5;
    logic [WORD_W-1:0] out_word_6;
    logic [WORD_W-1:0] out_word_7;
    logic [WORD_W-1:0] out_word_8;
    logic [WORD_W-1:0] out_word_9;
    logic [WORD_W-1:0] out_word_10;
    logic [WORD_W-1:0] out_word_11;
  } out_res_t;

  function automatic state_t req_to_state(in_req_t r);
    state_t s;
    s[0]  = r.in_word_0;
    s[1]  = r.in_word_1;
    s[2]  = r.in_word_2;
    s[3]  = r.in_word_3;
    s[4]  = r.in_word_4;
    s[5]  = r.in_word_5;
    s[6]  = r.in_word_6;
    s[7]  = r.in_word_7;
    s[8]  = r.in_word_8;
    s[9]  = r.in_word_9;
    s[10] = r.in_word_10;
    s[11] = r.in_word_11;
    return s;
  endfunction

  function automatic out_res_t state_to_res(state_t s);
    out_res_t r;
    r.out_word_0  = s[0];
    r.out_word_1  = s[1];
    r.out_word_2  = s[2];
    r.out_word_3  = s[3];
    r.out_word_4  = s[4];
    r.out_word_5  = s[5];
    r.out_word_6  = s[6];
    r.out_word_7  = s[7];
    r.out_word_8  = s[8];
    r.out_word_9  = s[9];
    r.out_word_10 = s[10];
    r.out_word_11 = s[11];
    return r;
  endfunction

  // one full round: four column sp-boxes, then a word swap chosen by rnd[1:0]
  function automatic state_t perm_round(state_t s, logic [RIDX_W-1:0] rnd);
    state_t            t;
    state_t            u;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    t = s;
    for (int c = 0; c < 4; c++) begin
      x = {s[c][7:0], s[c][31:8]};          // rotl 24
      y = {s[c+4][22:0], s[c+4][31:23]};    // rotl 9
      z = s[c+8];
      t[c]   = z ^ y ^ ((x & y) << 3);
      t[c+4] = y ^ x ^ ((x | z) << 1);
      t[c+8] = x ^ (z << 1) ^ ((y & z) << 2);
    end
    u = t;
    case (rnd[1:0])
      2'd0: begin
        u[0] = t[1] ^ ROUND_CONST ^ WORD_W'(rnd);
        u[1] = t[0];
        u[2] = t[3];
        u[3] = t[2];
      end
      2'd2: begin
        u[0] = t[2];
        u[1] = t[3];
        u[2] = t[0];
        u[3] = t[1];
      end
      default: begin
        u = t;
      end
    endcase
    return u;
  endfunction

endpackage

/* sv/pm384_whiten.sv */
// ----------------------------------------------------------------------------
// pm384_whiten: key whitening stage
// xors the key into words 0..7 and registers the block with its valid bit
// ----------------------------------------------------------------------------
module pm384_whiten
  import pm384_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   vld_i,
  input  state_t state_i,
  input  key_t   key_i,
  output logic   vld_o,
  output state_t state_o
);

  logic   vld_r;
  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_i;
    for (int i = 0; i < KEY_WORDS; i++) begin
      state_nxt[i] = state_i[i] ^ key_i[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
  end

  assign vld_o   = vld_r;
  assign state_o = state_r;

endmodule

/* sv/pm384_round.sv */
// ----------------------------------------------------------------------------
// pm384_round: one permutation round stage
// applies one round selected by the stage's round number, then registers it
// ----------------------------------------------------------------------------
module pm384_round
  import pm384_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RIDX_W-1:0] round_idx,
  input  logic              vld_i,
  input  state_t            state_i,
  output logic              vld_o,
  output state_t            state_o
);

  logic   vld_r;
  state_t state_r;
  state_t state_nxt;

  assign state_nxt = perm_round(state_i, round_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
  end

  assign vld_o   = vld_r;
  assign state_o = state_r;

endmodule

/* sv/perm384_even_mansour_cipher.sv */
// path: a request accepted at an edge loads the input whitening register, then
//   passes the 24 round registers and the output whitening register, which raises
//   the result strobe; set by the one-round-per-stage pipeline
// throughput: one request per cycle, busy stays low in normal operation
// reset: synchronous active-low; clears the key and all stage valid bits,
//   busy is high for the first cycle after reset is released
// ----------------------------------------------------------------------------
// perm384_even_mansour_cipher: keyed 384-bit permutation cipher
// even-mansour construction around a 24-round column sp-box permutation,
// fully unrolled into one pipeline stage per round
// ----------------------------------------------------------------------------
module perm384_even_mansour_cipher
  import pm384_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEYREG_W-1:0]  cfg_wdata,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  in_req_t              in_req,
  // result channel, one cycle strobe, no back pressure
  output logic                 out_valid,
  output out_res_t             out_res
);

  // key registers, pair i holds key words 2i (low) and 2i+1 (high)
  logic [NUM_KEYREGS-1:0][KEYREG_W-1:0] key_r;
  key_t                                 key_words;
  logic                                 busy_r;
  logic                                 accept;

  // per stage valid and block; index 0 is the whitened input
  logic   stg_vld   [ROUND_COUNT+1];
  state_t stg_state [ROUND_COUNT+1];

  logic   fin_vld;
  state_t fin_state;

  // packed layout of the pairs matches the key word order directly
  assign key_words = key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  // busy only covers the cycle right after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // input whitening
  pm384_whiten u_win (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (accept),
    .state_i (req_to_state(in_req)),
    .key_i   (key_words),
    .vld_o   (stg_vld[0]),
    .state_o (stg_state[0])
  );

  // one registered round per stage
  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    pm384_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .round_idx (RIDX_W'(g)),
      .vld_i     (stg_vld[g]),
      .state_i   (stg_state[g]),
      .vld_o     (stg_vld[g+1]),
      .state_o   (stg_state[g+1])
    );
  end

  // output whitening, also the result register
  pm384_whiten u_wout (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (stg_vld[ROUND_COUNT]),
    .state_i (stg_state[ROUND_COUNT]),
    .key_i   (key_words),
    .vld_o   (fin_vld),
    .state_o (fin_state)
  );

  assign out_valid = fin_vld;
  assign out_res   = state_to_res(fin_state);

endmodule

/* sv/pm384_checker.sv */
// ----------------------------------------------------------------------------
// pm384_checker: port level checks
// fixed latency between accepted requests and result strobes
// ----------------------------------------------------------------------------
module pm384_checker
  import pm384_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  logic accept;
  assign accept = start && !busy;

  // every accepted request yields a strobe after the fixed latency
  a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("request accepted without a result after the pipeline latency");

  // no strobe without a request accepted the same latency earlier
  a_res_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result strobe without a matching request");

  // busy only right after reset
  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy asserted outside the cycle after reset");

endmodule

bind perm384_even_mansour_cipher pm384_checker u_pm384_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
